// ----- hw/rtl/fqrs_pkg.sv -----
// Shared types and constants for the reversible search queue.
package fqrs_pkg;

   // Fixed payload widths of the request and response channels
   localparam int OPCODE_WIDTH = 3;
   localparam int VALUE_WIDTH  = 32;
   localparam int COUNT_WIDTH  = 5;

   // Request opcodes
   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_ENQUEUE = 3'd0,
      OP_DEQUEUE = 3'd1,
      OP_QUERY   = 3'd2,
      OP_SWAP    = 3'd3,
      OP_REVERSE = 3'd4,
      OP_CLEAR   = 3'd5,
      OP_SEARCH  = 3'd6
   } opcode_type;

   // Data move broadcast to every cell of the row
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN,
      CELL_WRITE_AT,
      CELL_SWAP
   } cell_mode_type;

   // Broadcast control from the sequencer to the cell row
   typedef struct packed {
      cell_mode_type mode;
      logic          scan_clear;
      logic          scan_step;
   } cell_ctrl_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_REPORT = 3'b100
   } state_type;

endpackage

// ----- hw/rtl/fqrs_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface fqrs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [fqrs_pkg::OPCODE_WIDTH-1:0]     opcode;
   logic signed [fqrs_pkg::VALUE_WIDTH-1:0] value;

   modport source (output valid, opcode, value, input ready);
   modport sink   (input valid, opcode, value, output ready);
endinterface

interface fqrs_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [fqrs_pkg::VALUE_WIDTH-1:0] front_value;
   logic                                    front_valid;
   logic [fqrs_pkg::COUNT_WIDTH-1:0]        entry_count;
   logic                                    empty_flag;
   logic                                    found_flag;
   logic                                    overflow_flag;

   modport source (output valid, front_value, front_valid, entry_count, empty_flag,
                   found_flag, overflow_flag, input ready);
   modport sink   (input valid, front_value, front_valid, entry_count, empty_flag,
                   found_flag, overflow_flag, output ready);
endinterface

// ----- hw/rtl/fifo_queue_with_reverse_and_search.sv -----
// Top level: bounded FIFO with end swap, reversal and membership search.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+------------------------------------------------
//   req_bus   | in  | valid / ready | opcode[2:0], value[31:0] signed
//   rsp_bus   | out | valid / ready | front_value, front_valid, entry_count[4:0],
//             |     |               | empty_flag, found_flag, overflow_flag
//
// Every operation but search updates the cell row when it is accepted, then loads the
// response register in the report state. Search passes first through a scan state, in
// which the hit bit ripples one cell per cycle down the row. Reset is synchronous and
// clears count, head side, direction and the handshake state. A stalled response holds
// in its register; the next transaction is taken while it waits and only its report
// step stalls.
module fifo_queue_with_reverse_and_search #(
   parameter int QUEUE_DEPTH = 16,
   parameter int WORD_WIDTH  = 32
) (
   input logic        clock,
   input logic        reset,
   fqrs_req_if.sink   req_bus,
   fqrs_rsp_if.source rsp_bus
);

   localparam int CountW = $clog2(QUEUE_DEPTH + 1);
   localparam int ScanW  = $clog2(QUEUE_DEPTH);
   localparam int VW     = fqrs_pkg::VALUE_WIDTH;

   fqrs_pkg::state_type     state_ff, state_in;
   logic [CountW-1:0]       count_ff, count_in;
   logic                    rev_ff, rev_in;
   logic                    overflow_ff, overflow_in;
   logic                    search_ff, search_in;
   logic [WORD_WIDTH-1:0]   key_ff, key_in;
   logic [ScanW-1:0]        scan_cnt_ff, scan_cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0]    rsp_front_ff, rsp_front_in;
   logic                    rsp_front_valid_ff, rsp_front_valid_in;
   logic [fqrs_pkg::COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic                    rsp_overflow_ff, rsp_overflow_in;

   fqrs_pkg::cell_ctrl_type ctrl;
   fqrs_pkg::opcode_type    req_op;
   logic                    req_fire;
   logic                    rsp_free;
   logic [WORD_WIDTH-1:0]   req_word;
   logic [WORD_WIDTH-1:0]   key_word;
   logic [WORD_WIDTH-1:0]   last_word;
   logic [WORD_WIDTH-1:0]   front_word;
   logic [CountW-1:0]       last_idx;
   logic signed [63:0]      front_wide;

   logic [WORD_WIDTH-1:0]   cell_word [QUEUE_DEPTH];
   logic                    cell_hit  [QUEUE_DEPTH];

   assign req_bus.ready = (state_ff == fqrs_pkg::ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_op        = fqrs_pkg::opcode_type'(req_bus.opcode);
   assign req_word      = req_bus.value[WORD_WIDTH-1:0];
   assign key_word      = (state_ff == fqrs_pkg::ST_SCAN) ? key_ff : req_word;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign last_idx      = count_ff - CountW'(1);

   // Pick the rear cell of the occupied run
   always_comb begin
      last_word = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (CountW'(i) == last_idx) last_word = cell_word[i];
      end
   end

   assign front_word = rev_ff ? last_word : cell_word[0];
   assign front_wide = 64'($signed(front_word));

   // Cell row
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      fqrs_cell #(
         .QUEUE_DEPTH (QUEUE_DEPTH),
         .WORD_WIDTH  (WORD_WIDTH),
         .CELL_INDEX  (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .count      (count_ff),
         .key_word   (key_word),
         .first_word (cell_word[0]),
         .last_word  (last_word),
         .left_word  ((g == 0) ? key_word : cell_word[(g == 0) ? 0 : g - 1]),
         .right_word (cell_word[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
         .left_hit   ((g == 0) ? 1'b0 : cell_hit[(g == 0) ? 0 : g - 1]),
         .word_ff    (cell_word[g]),
         .hit_ff     (cell_hit[g])
      );
   end

   // Sequence the transaction: execute, scan, report
   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      rev_in             = rev_ff;
      overflow_in        = overflow_ff;
      search_in          = search_ff;
      key_in             = key_ff;
      scan_cnt_in        = scan_cnt_ff;
      ctrl.mode          = fqrs_pkg::CELL_HOLD;
      ctrl.scan_clear    = 1'b0;
      ctrl.scan_step     = 1'b0;
      rsp_valid_in       = rsp_valid_ff && !rsp_bus.ready;
      rsp_front_in       = rsp_front_ff;
      rsp_front_valid_in = rsp_front_valid_ff;
      rsp_count_in       = rsp_count_ff;
      rsp_found_in       = rsp_found_ff;
      rsp_overflow_in    = rsp_overflow_ff;

      unique case (state_ff)
         fqrs_pkg::ST_IDLE: begin
            if (req_fire) begin
               overflow_in = 1'b0;
               search_in   = 1'b0;
               key_in      = req_word;
               state_in    = fqrs_pkg::ST_REPORT;
               case (req_op)
                  fqrs_pkg::OP_ENQUEUE: begin
                     if (count_ff == CountW'(QUEUE_DEPTH)) begin
                        overflow_in = 1'b1;
                     end else begin
                        ctrl.mode = rev_ff ? fqrs_pkg::CELL_SHIFT_UP
                                           : fqrs_pkg::CELL_WRITE_AT;
                        count_in  = count_ff + CountW'(1);
                     end
                  end
                  fqrs_pkg::OP_DEQUEUE: begin
                     if (count_ff != '0) begin
                        ctrl.mode = rev_ff ? fqrs_pkg::CELL_HOLD
                                           : fqrs_pkg::CELL_SHIFT_DOWN;
                        count_in  = count_ff - CountW'(1);
                     end
                  end
                  fqrs_pkg::OP_SWAP: begin
                     if (count_ff != '0) ctrl.mode = fqrs_pkg::CELL_SWAP;
                  end
                  fqrs_pkg::OP_REVERSE: rev_in = !rev_ff;
                  fqrs_pkg::OP_CLEAR:   count_in = '0;
                  fqrs_pkg::OP_SEARCH: begin
                     search_in       = 1'b1;
                     ctrl.scan_clear = 1'b1;
                     scan_cnt_in     = '0;
                     state_in        = fqrs_pkg::ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         fqrs_pkg::ST_SCAN: begin
            ctrl.scan_step = 1'b1;
            scan_cnt_in    = scan_cnt_ff + ScanW'(1);
            if (scan_cnt_ff == ScanW'(QUEUE_DEPTH - 1)) state_in = fqrs_pkg::ST_REPORT;
         end
         fqrs_pkg::ST_REPORT: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_front_valid_in = (count_ff != '0);
               rsp_front_in       = (count_ff != '0) ? front_wide[VW-1:0] : '0;
               rsp_count_in       = fqrs_pkg::COUNT_WIDTH'(count_ff);
               rsp_found_in       = search_ff && cell_hit[QUEUE_DEPTH-1];
               rsp_overflow_in    = overflow_ff;
               state_in           = fqrs_pkg::ST_IDLE;
            end
         end
         default: state_in = fqrs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff             <= key_in;
      scan_cnt_ff        <= scan_cnt_in;
      overflow_ff        <= overflow_in;
      search_ff          <= search_in;
      rsp_front_ff       <= rsp_front_in;
      rsp_front_valid_ff <= rsp_front_valid_in;
      rsp_count_ff       <= rsp_count_in;
      rsp_found_ff       <= rsp_found_in;
      rsp_overflow_ff    <= rsp_overflow_in;
      if (reset) begin
         state_ff     <= fqrs_pkg::ST_IDLE;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Drive the response channel
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.front_value   = rsp_front_ff;
   assign rsp_bus.front_valid   = rsp_front_valid_ff;
   assign rsp_bus.entry_count   = rsp_count_ff;
   assign rsp_bus.empty_flag    = !rsp_front_valid_ff;
   assign rsp_bus.found_flag    = rsp_found_ff;
   assign rsp_bus.overflow_flag = rsp_overflow_ff;

endmodule

// ----- hw/rtl/fqrs_cell.sv -----
// One queue cell: holds one word and one bit of the search hit chain.
module fqrs_cell #(
   parameter int QUEUE_DEPTH = 16,
   parameter int WORD_WIDTH  = 32,
   parameter int CELL_INDEX  = 0,
   localparam int CountW     = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fqrs_pkg::cell_ctrl_type ctrl,
   input  logic [CountW-1:0]       count,
   input  logic [WORD_WIDTH-1:0]   key_word,
   input  logic [WORD_WIDTH-1:0]   first_word,
   input  logic [WORD_WIDTH-1:0]   last_word,
   input  logic [WORD_WIDTH-1:0]   left_word,
   input  logic [WORD_WIDTH-1:0]   right_word,
   input  logic                    left_hit,
   output logic [WORD_WIDTH-1:0]   word_ff,
   output logic                    hit_ff
);

   localparam logic [CountW-1:0] CellIdx = CountW'(CELL_INDEX);

   logic [WORD_WIDTH-1:0] word_in;
   logic                  hit_in;
   logic [CountW-1:0]     last_idx;
   logic                  live;

   assign last_idx = count - CountW'(1);
   assign live     = (CellIdx < count);

   // Select the word this cell takes
   always_comb begin
      word_in = word_ff;
      unique case (ctrl.mode)
         fqrs_pkg::CELL_HOLD:       word_in = word_ff;
         fqrs_pkg::CELL_SHIFT_UP:   word_in = left_word;
         fqrs_pkg::CELL_SHIFT_DOWN: word_in = right_word;
         fqrs_pkg::CELL_WRITE_AT: begin
            if (CellIdx == count) word_in = key_word;
         end
         fqrs_pkg::CELL_SWAP: begin
            if (CellIdx == '0) word_in = last_word;
            else if (CellIdx == last_idx) word_in = first_word;
         end
         default:                   word_in = word_ff;
      endcase
   end

   // Advance the hit chain: OR in this cell's match one cell per cycle
   always_comb begin
      hit_in = hit_ff;
      if (ctrl.scan_clear) hit_in = 1'b0;
      else if (ctrl.scan_step) hit_in = left_hit | (live && (word_ff == key_word));
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

endmodule

// ----- hw/rtl/fqrs_checker.sv -----
// Port-level checks on the queue's response channel, bound to the top level.
module fqrs_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [fqrs_pkg::VALUE_WIDTH-1:0] rsp_front_value,
   input logic                                    rsp_front_valid,
   input logic [fqrs_pkg::COUNT_WIDTH-1:0]        rsp_entry_count,
   input logic                                    rsp_empty_flag,
   input logic                                    rsp_found_flag,
   input logic                                    rsp_overflow_flag
);

   // Hold a stalled transaction
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_front_value) && $stable(rsp_entry_count))
      else $error("response payload changed while stalled");

   // An empty queue shows no front and a zero count
   a_empty_view: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_flag |-> !rsp_front_valid && rsp_entry_count == '0
         && rsp_front_value == '0)
      else $error("empty response with a front entry");

   // A dropped enqueue only happens on a full queue
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow_flag |->
         rsp_entry_count == fqrs_pkg::COUNT_WIDTH'(QUEUE_DEPTH) && !rsp_found_flag)
      else $error("overflow reported on a queue that is not full");

   // A search hit needs at least one entry
   a_found_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found_flag |-> rsp_front_valid)
      else $error("search hit on an empty queue");

endmodule

bind fifo_queue_with_reverse_and_search fqrs_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fqrs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_front_value   (rsp_bus.front_value),
   .rsp_front_valid   (rsp_bus.front_valid),
   .rsp_entry_count   (rsp_bus.entry_count),
   .rsp_empty_flag    (rsp_bus.empty_flag),
   .rsp_found_flag    (rsp_bus.found_flag),
   .rsp_overflow_flag (rsp_bus.overflow_flag)
);

// ----- verif/tb_fifo_queue_with_reverse_and_search.sv -----
// Testbench for the reversible search queue: directed and random valid/ready traffic checked by a queue model.
`timescale 1ns / 100ps

module tb_fifo_queue_with_reverse_and_search;

   localparam int QUEUE_DEPTH = 16;
   localparam int WORD_WIDTH  = 32;
   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int BATCH_ITEMS = 105;
   localparam logic [fqrs_pkg::OPCODE_WIDTH-1:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic [fqrs_pkg::OPCODE_WIDTH-1:0] opcode;
      logic [fqrs_pkg::VALUE_WIDTH-1:0]  value;
   } queue_request_type;

   typedef struct packed {
      logic signed [fqrs_pkg::VALUE_WIDTH-1:0] front_value;
      logic                                    front_valid;
      logic [fqrs_pkg::COUNT_WIDTH-1:0]        entry_count;
      logic                                    empty_flag;
      logic                                    found_flag;
      logic                                    overflow_flag;
   } queue_status_type;

   logic clock = 1'b0;
   logic reset;

   fqrs_req_if req_bus ();
   fqrs_rsp_if rsp_bus ();

   fifo_queue_with_reverse_and_search #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // Queue model state
   logic [fqrs_pkg::VALUE_WIDTH-1:0] model_words [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]             model_head;
   logic [fqrs_pkg::COUNT_WIDTH-1:0] model_count;
   logic                             model_reversed;

   queue_request_type pending_requests[$];
   queue_status_type  expected_status[$];
   logic [fqrs_pkg::VALUE_WIDTH-1:0] value_pool [8];

   int issued_count;
   int accepted_count = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   int send_idle_pct;
   int recv_stall_pct;

   always #1 clock = ~clock;

   function automatic int slot_at(input int offset);
      return (int'(model_head) + offset) % QUEUE_DEPTH;
   endfunction

   function automatic int front_slot();
      return model_reversed ? slot_at(int'(model_count) - 1) : slot_at(0);
   endfunction

   // Apply one operation to the queue model and return the status it reports
   function automatic queue_status_type apply_queue_op(
         input logic [fqrs_pkg::OPCODE_WIDTH-1:0] op,
         input logic [fqrs_pkg::VALUE_WIDTH-1:0] word);
      queue_status_type status;
      int front_idx;
      int rear_idx;
      logic [fqrs_pkg::VALUE_WIDTH-1:0] held_word;
      status = '0;
      case (op)
         fqrs_pkg::OP_ENQUEUE: begin
            if (model_count >= QUEUE_DEPTH) begin
               status.overflow_flag = 1'b1;
            end else if (model_reversed) begin
               model_head = PTR_WIDTH'((int'(model_head) + QUEUE_DEPTH - 1) % QUEUE_DEPTH);
               model_words[model_head] = word;
               model_count = model_count + 1'b1;
            end else begin
               model_words[slot_at(int'(model_count))] = word;
               model_count = model_count + 1'b1;
            end
         end
         fqrs_pkg::OP_DEQUEUE: begin
            if (model_count > 0) begin
               if (!model_reversed)
                  model_head = PTR_WIDTH'(slot_at(1));
               model_count = model_count - 1'b1;
            end
         end
         fqrs_pkg::OP_SWAP: begin
            if (model_count > 0) begin
               front_idx = front_slot();
               rear_idx = model_reversed ? slot_at(0) : slot_at(int'(model_count) - 1);
               held_word = model_words[front_idx];
               model_words[front_idx] = model_words[rear_idx];
               model_words[rear_idx] = held_word;
            end
         end
         fqrs_pkg::OP_REVERSE: model_reversed = ~model_reversed;
         fqrs_pkg::OP_CLEAR: begin
            model_count = '0;
            model_head = '0;
         end
         fqrs_pkg::OP_SEARCH: begin
            for (int i = 0; i < int'(model_count); i++)
               if (model_words[slot_at(i)] == word)
                  status.found_flag = 1'b1;
         end
         default: ;
      endcase
      // Report the queue as it stands after the operation
      if (model_count > 0) begin
         status.front_value = model_words[front_slot()];
         status.front_valid = 1'b1;
      end else begin
         status.empty_flag = 1'b1;
      end
      status.entry_count = model_count;
      return status;
   endfunction

   task automatic add_request(input logic [fqrs_pkg::OPCODE_WIDTH-1:0] op,
                              input logic [fqrs_pkg::VALUE_WIDTH-1:0] word);
      queue_request_type req;
      req.opcode = op;
      req.value = word;
      pending_requests.push_back(req);
      issued_count++;
   endtask

   task automatic report_mismatch(input string what, input queue_status_type want,
                                  input queue_status_type seen);
      if (mismatch_count < 10)
         $display("ERROR %s: expected value=%0d valid=%0b count=%0d empty=%0b found=%0b ovf=%0b",
                  what, want.front_value, want.front_valid, want.entry_count,
                  want.empty_flag, want.found_flag, want.overflow_flag,
                  ", got value=%0d valid=%0b count=%0d empty=%0b found=%0b ovf=%0b",
                  seen.front_value, seen.front_valid, seen.entry_count,
                  seen.empty_flag, seen.found_flag, seen.overflow_flag);
      mismatch_count++;
   endtask

   // Build random runs that swing between filling, draining and mixed traffic
   task automatic add_random_requests(input int count);
      int tendency;
      int enq_cut;
      int deq_cut;
      int pick;
      logic [fqrs_pkg::OPCODE_WIDTH-1:0] op;
      logic [fqrs_pkg::VALUE_WIDTH-1:0] word;
      tendency = 0;
      enq_cut = 0;
      deq_cut = 0;
      for (int n = 0; n < count; n++) begin
         if (n % 24 == 0) begin
            tendency = $urandom_range(2);
            enq_cut = (tendency == 0) ? 60 : (tendency == 1) ? 15 : 35;
            deq_cut = enq_cut + ((tendency == 0) ? 10 : (tendency == 1) ? 45 : 20);
         end
         pick = $urandom_range(99);
         if (pick < enq_cut) begin
            op = fqrs_pkg::OP_ENQUEUE;
         end else if (pick < deq_cut) begin
            op = fqrs_pkg::OP_DEQUEUE;
         end else begin
            pick = $urandom_range(99);
            if (pick < 15)      op = fqrs_pkg::OP_QUERY;
            else if (pick < 35) op = fqrs_pkg::OP_SWAP;
            else if (pick < 50) op = fqrs_pkg::OP_REVERSE;
            else if (pick < 90) op = fqrs_pkg::OP_SEARCH;
            else if (pick < 96) op = fqrs_pkg::OP_CLEAR;
            else                op = OP_UNUSED;
         end
         // Reuse pool words half the time so searches hit
         word = $urandom_range(1) ? value_pool[$urandom_range(7)]
                                  : fqrs_pkg::VALUE_WIDTH'($urandom);
         add_request(op, word);
      end
   endtask

   task automatic wait_all_accepted();
      while (accepted_count < issued_count)
         @(posedge clock);
   endtask

   // Drive request transactions and predict the response of each accepted one
   always @(posedge clock) begin : drive_requests
      queue_request_type next_req;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.opcode <= '0;
         req_bus.value <= '0;
         model_head = '0;
         model_count = '0;
         model_reversed = 1'b0;
         foreach (model_words[i])
            model_words[i] = '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_status.push_back(apply_queue_op(req_bus.opcode, req_bus.value));
            accepted_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pending_requests.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.opcode <= next_req.opcode;
               req_bus.value <= next_req.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Compare each response transaction with the oldest prediction
   always @(posedge clock) begin : check_responses
      queue_status_type seen;
      queue_status_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.front_value = rsp_bus.front_value;
            seen.front_valid = rsp_bus.front_valid;
            seen.entry_count = rsp_bus.entry_count;
            seen.empty_flag = rsp_bus.empty_flag;
            seen.found_flag = rsp_bus.found_flag;
            seen.overflow_flag = rsp_bus.overflow_flag;
            if (expected_status.size() == 0) begin
               report_mismatch("unexpected response", '0, seen);
            end else begin
               want = expected_status.pop_front();
               if (seen !== want)
                  report_mismatch("response differs", want, seen);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // End the run when neither channel moves for too long
   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      issued_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < 8; i++)
         value_pool[i] = $urandom;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Operations on an empty queue, including the unused opcode
      add_request(fqrs_pkg::OP_DEQUEUE, 32'h0);
      add_request(fqrs_pkg::OP_SWAP, 32'h0);
      add_request(fqrs_pkg::OP_SEARCH, 32'h0);
      add_request(fqrs_pkg::OP_REVERSE, 32'h0);
      add_request(fqrs_pkg::OP_REVERSE, 32'h0);
      add_request(OP_UNUSED, 32'hffff_ffff);
      add_request(fqrs_pkg::OP_QUERY, 32'h0);
      // Swap with a single entry
      add_request(fqrs_pkg::OP_ENQUEUE, 32'h8000_0000);
      add_request(fqrs_pkg::OP_SWAP, 32'h0);
      // Fill to capacity, then overflow
      add_request(fqrs_pkg::OP_ENQUEUE, 32'h7fff_ffff);
      add_request(fqrs_pkg::OP_ENQUEUE, 32'h0000_0000);
      add_request(fqrs_pkg::OP_ENQUEUE, 32'hffff_ffff);
      for (int i = 0; i < QUEUE_DEPTH - 4; i++)
         add_request(fqrs_pkg::OP_ENQUEUE,
                     value_pool[4 + i % 4] ^ fqrs_pkg::VALUE_WIDTH'(i));
      add_request(fqrs_pkg::OP_ENQUEUE, 32'h5555_aaaa);
      add_request(fqrs_pkg::OP_SEARCH, 32'h7fff_ffff);
      add_request(fqrs_pkg::OP_SEARCH, 32'h0000_0001);
      // Swap and enqueue in both directions, then clear while reversed
      add_request(fqrs_pkg::OP_SWAP, 32'h0);
      add_request(fqrs_pkg::OP_REVERSE, 32'h0);
      add_request(fqrs_pkg::OP_SWAP, 32'h0);
      add_request(fqrs_pkg::OP_DEQUEUE, 32'h0);
      add_request(fqrs_pkg::OP_ENQUEUE, 32'haaaa_5555);
      add_request(fqrs_pkg::OP_CLEAR, 32'h0);
      add_request(fqrs_pkg::OP_QUERY, 32'h0);
      wait_all_accepted();

      // Random traffic under each idling pattern, twice over
      for (int round = 0; round < 2; round++) begin
         for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1) ? 72 : (phase == 3) ? 18 : 0;
            recv_stall_pct = (phase == 2) ? 72 : (phase == 3) ? 18 : 0;
            add_random_requests(BATCH_ITEMS);
            wait_all_accepted();
         end
      end

      // Drain outstanding responses, then allow stray ones to show up
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (expected_status.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
